@@ design/detr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// detr_pkg: shared types and constants of the event trace ring
// Record layout, command and result words, kind codes and the byte mask
// helper used by the front end and the back end.
// ----------------------------------------------------------------------------
package detr_pkg;

  // ring geometry
  localparam int CAP        = 256;
  localparam int SLOT_W     = $clog2(CAP);
  localparam int CNT_W      = 9;
  localparam int MAX_PB     = 8;
  localparam int LEN_W      = 4;
  localparam int PARAM_W    = 64;
  localparam int MAX_READ   = 64;
  localparam int READ_W     = 7;

  // queue geometry
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

  // result kinds, also used as command codes
  typedef enum logic [1:0] {
    KIND_NEW  = 2'd0,
    KIND_DUP  = 2'd1,
    KIND_READ = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  // one stored record
  typedef struct packed {
    logic [7:0]         func;
    logic [31:0]        stamp;
    logic [31:0]        ret;
    logic [31:0]        repeats;
    logic [LEN_W-1:0]   length;
    logic [PARAM_W-1:0] params;
  } rec_t;

  // word from the front end to the back end
  typedef struct packed {
    kind_t              kind;
    logic [SLOT_W-1:0]  slot;
    rec_t               rec;
    logic [31:0]        start;
    logic [31:0]        diff;
    logic [READ_W-1:0]  maxc;
    logic [CNT_W-1:0]   held;
    logic [31:0]        head;
  } cmd_t;

  // result word
  typedef struct packed {
    kind_t              kind;
    rec_t               rec;
    logic               last;
    logic [31:0]        next;
    logic [CNT_W-1:0]   held;
    logic [31:0]        head;
  } res_t;

  // ones in the low len bytes
  function automatic logic [PARAM_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
    logic [PARAM_W-1:0] m;
    m = '0;
    for (int i = 0; i < PARAM_W / 8; i++) begin
      if (LEN_W'(i) < len) begin
        m[8*i +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage
`default_nettype wire

@@ design/dedup_event_trace_ring_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dedup_event_trace_ring_unit: event trace ring with repeat counting
// Front end classifies words, a command queue decouples it from the back end
// that owns the 256-entry record memory and feeds the result queue.
// ----------------------------------------------------------------------------
// Pushes, new or repeated, stream at one word per cycle while the back end is
// idle and the result queue has room; each gives one result word. A read that
// returns n records passes through the step that takes it, the setup states
// ST_COUNT and ST_NEXT that size the read, one record memory read per cycle
// while the result queue has room, and a last step that writes the final
// record word; the single read port of the record memory sets that pace. A
// read that returns nothing gives a single result word, like a push. The
// result word of a push passes through the command queue and the result
// queue to the result ports. The record memory needs no clearing after reset:
// reading a slot never written gives unspecified record fields.
module dedup_event_trace_ring_unit (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  output logic                     full,
  input  wire logic                mode,
  input  wire logic [7:0]          func_id,
  input  wire logic signed [31:0]  return_code,
  input  wire logic [31:0]         time_ms,
  input  wire logic [15:0]         param_length,
  input  wire logic [63:0]         param_bytes,
  input  wire logic [31:0]         start_index,
  input  wire logic [6:0]          max_count,
  output logic                     empty,
  input  wire logic                pop,
  output logic [1:0]               result_kind,
  output logic [7:0]               record_func,
  output logic [31:0]              record_time,
  output logic signed [31:0]       record_return,
  output logic [31:0]              record_repeats,
  output logic [3:0]               record_length,
  output logic [63:0]              record_params,
  output logic                     last_of_run,
  output logic [31:0]              next_index,
  output logic [8:0]               stored_count,
  output logic [31:0]              head_position
);

  logic                                  accept;
  detr_pkg::cmd_t                        front_cmd;
  detr_pkg::cmd_t                        back_cmd;
  logic                                  cmd_empty;
  logic                                  cmd_pop;
  logic [detr_pkg::OUTQ_CNT_W-1:0]       out_count;
  logic                                  out_push;
  detr_pkg::res_t                        out_wdata;
  detr_pkg::res_t                        out_rdata;

  assign accept = push && !full;

  // classify incoming words
  detr_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .mode         (mode),
    .func_id      (func_id),
    .return_code  (return_code),
    .time_ms      (time_ms),
    .param_length (param_length),
    .param_bytes  (param_bytes),
    .start_index  (start_index),
    .max_count    (max_count),
    .cmd          (front_cmd)
  );

  // command queue
  detr_cmd_queue u_cmd_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (accept),
    .wdata (front_cmd),
    .full  (full),
    .pop   (cmd_pop),
    .empty (cmd_empty),
    .rdata (back_cmd)
  );

  // record store and execution
  detr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (back_cmd),
    .cmd_pop   (cmd_pop),
    .out_count (out_count),
    .out_push  (out_push),
    .out_data  (out_wdata)
  );

  // result queue
  detr_out_queue u_out_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (out_wdata),
    .count (out_count),
    .pop   (pop),
    .empty (empty),
    .rdata (out_rdata)
  );

  // result ports
  assign result_kind    = out_rdata.kind;
  assign record_func    = out_rdata.rec.func;
  assign record_time    = out_rdata.rec.stamp;
  assign record_return  = out_rdata.rec.ret;
  assign record_repeats = out_rdata.rec.repeats;
  assign record_length  = out_rdata.rec.length;
  assign record_params  = out_rdata.rec.params;
  assign last_of_run    = out_rdata.last;
  assign next_index     = out_rdata.next;
  assign stored_count   = out_rdata.held;
  assign head_position  = out_rdata.head;

  // result queue never overflows, reads in flight included
  a_outq_room: assert property (@(posedge clk) disable iff (rst)
    out_push |-> (out_count < detr_pkg::OUTQ_CNT_W'(detr_pkg::OUTQ_DEPTH)))
    else $error("result queue written while full");

  // every word other than a read record ends its run
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && (result_kind != detr_pkg::KIND_READ)) |-> last_of_run)
    else $error("single result without last flag");

  // held count stays within the ring
  a_held_cap: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (stored_count <= 9'(detr_pkg::CAP)))
    else $error("stored count above capacity");

endmodule
`default_nettype wire

@@ design/detr_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// detr_front: accept and classify incoming words
// Tracks the last record, head and held count, decides new or repeat for
// pushes, clamps reads, and hands one command word per item to the back end.
// ----------------------------------------------------------------------------
module detr_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           accept,
  input  wire logic                           mode,
  input  wire logic [7:0]                     func_id,
  input  wire logic signed [31:0]             return_code,
  input  wire logic [31:0]                    time_ms,
  input  wire logic [15:0]                    param_length,
  input  wire logic [detr_pkg::PARAM_W-1:0]   param_bytes,
  input  wire logic [31:0]                    start_index,
  input  wire logic [detr_pkg::READ_W-1:0]    max_count,
  output detr_pkg::cmd_t                      cmd
);

  // front state
  logic                          prev_valid;
  detr_pkg::rec_t                prev;
  logic [31:0]                   head;
  logic [detr_pkg::CNT_W-1:0]    held;
  logic [31:0]                   oldest;

  logic                          dup;
  logic [detr_pkg::LEN_W-1:0]    len_c;
  detr_pkg::rec_t                new_rec;
  detr_pkg::rec_t                dup_rec;
  logic [31:0]                   head_next;
  logic [detr_pkg::CNT_W-1:0]    held_next;
  logic [31:0]                   oldest_next;
  logic [detr_pkg::READ_W-1:0]   maxc_c;
  logic [31:0]                   start_c;
  logic                          nonempty;

  // repeat detection and new record
  always_comb begin
    dup = prev_valid && (prev.func == func_id) &&
          (param_length == 16'(prev.length)) &&
          (((prev.params ^ param_bytes) & detr_pkg::byte_mask(prev.length)) == '0);
    len_c = (param_length > 16'(detr_pkg::MAX_PB)) ? detr_pkg::LEN_W'(detr_pkg::MAX_PB)
                                                   : param_length[detr_pkg::LEN_W-1:0];
    new_rec.func    = func_id;
    new_rec.stamp   = time_ms;
    new_rec.ret     = return_code;
    new_rec.repeats = 32'd1;
    new_rec.length  = len_c;
    new_rec.params  = param_bytes & detr_pkg::byte_mask(len_c);
    dup_rec         = prev;
    dup_rec.repeats = prev.repeats + 32'd1;
  end

  // head, held count and oldest index after a new record
  always_comb begin
    head_next   = head + 32'd1;
    held_next   = (held < detr_pkg::CNT_W'(detr_pkg::CAP)) ? held + 1'b1 : held;
    oldest_next = ((head >= 32'(detr_pkg::CAP)) && (head != '1)) ? oldest + 32'd1 : '0;
  end

  // read clamping
  always_comb begin
    maxc_c   = (max_count > detr_pkg::READ_W'(detr_pkg::MAX_READ))
               ? detr_pkg::READ_W'(detr_pkg::MAX_READ) : max_count;
    start_c  = (start_index < oldest) ? oldest : start_index;
    nonempty = (start_index < head) && (oldest < head) && (maxc_c != '0);
  end

  // command word
  always_comb begin
    cmd = '0;
    cmd.held = held;
    cmd.head = head;
    if (!mode) begin
      if (dup) begin
        cmd.kind = detr_pkg::KIND_DUP;
        cmd.slot = detr_pkg::SLOT_W'(head - 32'd1);
        cmd.rec  = dup_rec;
      end else begin
        cmd.kind = detr_pkg::KIND_NEW;
        cmd.slot = head[detr_pkg::SLOT_W-1:0];
        cmd.rec  = new_rec;
        cmd.held = held_next;
        cmd.head = head_next;
      end
    end else begin
      cmd.kind  = nonempty ? detr_pkg::KIND_READ : detr_pkg::KIND_NONE;
      cmd.start = start_c;
      cmd.diff  = head - start_c;
      cmd.maxc  = maxc_c;
    end
  end

  // state update on accepted pushes
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_valid <= 1'b0;
      head       <= '0;
      held       <= '0;
      oldest     <= '0;
    end else if (accept && !mode) begin
      if (dup) begin
        prev <= dup_rec;
      end else begin
        prev       <= new_rec;
        prev_valid <= 1'b1;
        head       <= head_next;
        held       <= held_next;
        oldest     <= oldest_next;
      end
    end
  end

endmodule
`default_nettype wire

@@ design/detr_cmd_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// detr_cmd_queue: command queue between front end and back end
// Small first-word-fall-through queue of command words.
// ----------------------------------------------------------------------------
module detr_cmd_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire detr_pkg::cmd_t  wdata,
  output logic                 full,
  input  wire logic            pop,
  output logic                 empty,
  output detr_pkg::cmd_t       rdata
);

  detr_pkg::cmd_t                   mem [detr_pkg::CMDQ_DEPTH];
  logic [detr_pkg::CMDQ_PTR_W-1:0]  wptr;
  logic [detr_pkg::CMDQ_PTR_W-1:0]  rptr;
  logic [detr_pkg::CMDQ_CNT_W-1:0]  count;
  logic                             do_push;
  logic                             do_pop;

  assign full    = (count == detr_pkg::CMDQ_CNT_W'(detr_pkg::CMDQ_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == detr_pkg::CMDQ_PTR_W'(detr_pkg::CMDQ_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == detr_pkg::CMDQ_PTR_W'(detr_pkg::CMDQ_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ design/detr_out_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// detr_out_queue: result queue in front of the result ports
// First-word-fall-through queue of result words; reports its fill count so
// the back end can reserve room for memory reads in flight.
// ----------------------------------------------------------------------------
module detr_out_queue (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              push,
  input  wire detr_pkg::res_t                    wdata,
  output logic [detr_pkg::OUTQ_CNT_W-1:0]        count,
  input  wire logic                              pop,
  output logic                                   empty,
  output detr_pkg::res_t                         rdata
);

  detr_pkg::res_t                   mem [detr_pkg::OUTQ_DEPTH];
  logic [detr_pkg::OUTQ_PTR_W-1:0]  wptr;
  logic [detr_pkg::OUTQ_PTR_W-1:0]  rptr;
  logic                             full;
  logic                             do_push;
  logic                             do_pop;

  assign full    = (count == detr_pkg::OUTQ_CNT_W'(detr_pkg::OUTQ_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == detr_pkg::OUTQ_PTR_W'(detr_pkg::OUTQ_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == detr_pkg::OUTQ_PTR_W'(detr_pkg::OUTQ_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ design/detr_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// detr_back: record store and command execution
// Holds the record memory, writes new and repeated records, walks reads one
// record per cycle while the result queue has room, and pushes results there.
// ----------------------------------------------------------------------------
module detr_back (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cmd_empty,
  input  wire detr_pkg::cmd_t                    cmd,
  output logic                                   cmd_pop,
  input  wire logic [detr_pkg::OUTQ_CNT_W-1:0]   out_count,
  output logic                                   out_push,
  output detr_pkg::res_t                         out_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COUNT,
    ST_NEXT,
    ST_RUN
  } state_t;

  detr_pkg::rec_t                 mem [detr_pkg::CAP];
  detr_pkg::rec_t                 rd_data;

  state_t                         state;
  logic [detr_pkg::SLOT_W-1:0]    addr;
  logic [detr_pkg::READ_W-1:0]    remain;
  logic [detr_pkg::READ_W-1:0]    maxc;
  logic [31:0]                    start;
  logic [31:0]                    diff;
  logic [31:0]                    next;
  logic [31:0]                    head;
  logic [detr_pkg::CNT_W-1:0]     held;
  logic                           inflight;
  logic                           infl_last;

  logic                           take;
  logic                           wr_en;
  logic                           issue;

  // command take and read issue
  always_comb begin
    take  = (state == ST_IDLE) && !cmd_empty && !inflight &&
            (out_count < detr_pkg::OUTQ_CNT_W'(detr_pkg::OUTQ_DEPTH));
    wr_en = take && ((cmd.kind == detr_pkg::KIND_NEW) || (cmd.kind == detr_pkg::KIND_DUP));
    issue = (state == ST_RUN) &&
            ((out_count + detr_pkg::OUTQ_CNT_W'(inflight)) <
             detr_pkg::OUTQ_CNT_W'(detr_pkg::OUTQ_DEPTH));
  end

  assign cmd_pop = take;

  // record memory write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cmd.slot] <= cmd.rec;
    end
  end

  // record memory read port
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data <= mem[addr];
    end
  end

  // result word
  always_comb begin
    out_push = 1'b0;
    out_data = '0;
    if (inflight) begin
      out_push      = 1'b1;
      out_data.kind = detr_pkg::KIND_READ;
      out_data.rec  = rd_data;
      out_data.last = infl_last;
      out_data.next = next;
      out_data.held = held;
      out_data.head = head;
    end else if (take) begin
      out_data.last = 1'b1;
      out_data.held = cmd.held;
      out_data.head = cmd.head;
      case (cmd.kind)
        detr_pkg::KIND_NEW, detr_pkg::KIND_DUP: begin
          out_push      = 1'b1;
          out_data.kind = cmd.kind;
          out_data.rec  = cmd.rec;
        end
        detr_pkg::KIND_NONE: begin
          out_push      = 1'b1;
          out_data.kind = detr_pkg::KIND_NONE;
          out_data.next = cmd.start;
        end
        default: begin
          out_push = 1'b0;
        end
      endcase
    end
  end

  // read sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      inflight <= 1'b0;
    end else begin
      inflight <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (take && (cmd.kind == detr_pkg::KIND_READ)) begin
            start <= cmd.start;
            diff  <= cmd.diff;
            maxc  <= cmd.maxc;
            held  <= cmd.held;
            head  <= cmd.head;
            addr  <= cmd.start[detr_pkg::SLOT_W-1:0];
            state <= ST_COUNT;
          end
        end
        ST_COUNT: begin
          // records returned: the smaller of available and requested
          remain <= (diff < 32'(maxc)) ? diff[detr_pkg::READ_W-1:0] : maxc;
          state  <= ST_NEXT;
        end
        ST_NEXT: begin
          next  <= start + 32'(remain);
          state <= ST_RUN;
        end
        ST_RUN: begin
          if (issue) begin
            addr      <= addr + 1'b1;
            remain    <= remain - 1'b1;
            inflight  <= 1'b1;
            infl_last <= (remain == detr_pkg::READ_W'(1));
            if (remain == detr_pkg::READ_W'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
